// ----- hw/rtl/uartrm_pkg.sv -----
// Shared types and constants for the 16550-style UART register block.
`default_nettype none
package uartrm_pkg;

   // Defaults and fixed sizes
   localparam int unsigned MAX_ACCESS_BYTES_DEFAULT = 4;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned COUNT_W = 3;
   localparam logic [15:0] BASE_PORT_RESET = 16'd1016;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_RX    = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SIZE  = 2'd1;
   localparam logic [1:0] ST_PORT  = 2'd2;
   localparam logic [1:0] ST_ROUTE = 2'd3;

   // Interrupt routing states
   localparam logic [1:0] ROUTE_UNMAPPED = 2'd1;
   localparam logic [1:0] ROUTE_OK       = 2'd2;

   // Interrupt identities
   localparam logic [3:0] ID_NONE = 4'h1;
   localparam logic [3:0] ID_THRE = 4'h2;
   localparam logic [3:0] ID_RDA  = 4'h4;
   localparam logic [3:0] IIR_NOFIFO_MASK = 4'hF;

   // Register offsets from the base port
   typedef enum logic [2:0] {
      OFF_DATA = 3'd0,
      OFF_IER  = 3'd1,
      OFF_IIR  = 3'd2,
      OFF_LCR  = 3'd3,
      OFF_MCR  = 3'd4,
      OFF_LSR  = 3'd5,
      OFF_MSR  = 3'd6,
      OFF_SCR  = 3'd7
   } reg_off_type;

   // Bit positions
   localparam int unsigned IER_RDA_BIT = 0;
   localparam int unsigned IER_THRE_BIT = 1;
   localparam int unsigned LCR_DLAB_BIT = 7;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] port_address;
      logic [2:0]  byte_count;
      logic [31:0] write_data;
      logic [1:0]  irq_route;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] status;
      logic       irq_raise;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       last;
   } rsp_payload_type;

   // Work handed from the front end to the result sequencer
   typedef struct packed {
      logic [7:0]         read_data;
      logic [1:0]         status;
      logic               irq_raise;
      logic               is_tx;
      logic [COUNT_W-1:0] count;
      logic [31:0]        data;
   } job_type;

endpackage
`default_nettype wire

// ----- hw/rtl/uartrm_front.sv -----
// Front end: decodes each request, updates the register state, builds a job.
`default_nettype none
module uartrm_front #(
   parameter int unsigned MAX_ACCESS_BYTES = uartrm_pkg::MAX_ACCESS_BYTES_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [15:0]                   csr_wdata,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire uartrm_pkg::req_payload_type req_payload,
   input  wire                          queue_full,
   output logic                         push,
   output uartrm_pkg::job_type          push_job
);

   logic [15:0] base_ff;
   logic [7:0]  rx_ff, rx_in;
   logic        dr_ff, dr_in;
   logic        te_ff, te_in;
   logic [7:0]  ier_ff, ier_in;
   logic [7:0]  lcr_ff, lcr_in;
   logic [3:0]  pend_ff, pend_in;

   logic [15:0] off_full;
   logic [2:0]  off;
   logic        dlab;
   logic [7:0]  low;
   logic        size_ok;
   logic        try_raise;
   logic [3:0]  raise_id;
   logic [1:0]  st;
   logic [7:0]  rd;
   logic        raised;
   logic        is_tx;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign off_full = req_payload.port_address - base_ff;
   assign off      = off_full[2:0];
   assign dlab     = lcr_ff[uartrm_pkg::LCR_DLAB_BIT];
   assign low      = req_payload.write_data[7:0];
   assign size_ok  = (req_payload.byte_count >= 3'd1) &&
                     ({29'd0, req_payload.byte_count} <= 32'(MAX_ACCESS_BYTES));

   // Request decode and next register state
   always_comb begin
      rx_in     = rx_ff;
      dr_in     = dr_ff;
      te_in     = te_ff;
      ier_in    = ier_ff;
      lcr_in    = lcr_ff;
      pend_in   = pend_ff;
      st        = uartrm_pkg::ST_OK;
      rd        = 8'd0;
      raised    = 1'b0;
      is_tx     = 1'b0;
      try_raise = 1'b0;
      raise_id  = uartrm_pkg::ID_NONE;
      unique case (req_payload.req_type)
         uartrm_pkg::REQ_RX: begin
            rx_in     = low;
            dr_in     = 1'b1;
            try_raise = 1'b1;
         end
         uartrm_pkg::REQ_NONE: begin
         end
         uartrm_pkg::REQ_READ: begin
            if (off_full[15:3] != 13'd0) begin
               st = uartrm_pkg::ST_PORT;
            end else begin
               unique case (off)
                  uartrm_pkg::OFF_DATA: begin
                     rd    = rx_ff;
                     rx_in = 8'd0;
                     dr_in = 1'b0;
                     if ((pend_ff & uartrm_pkg::ID_RDA) != 4'd0) pend_in = uartrm_pkg::ID_NONE;
                     try_raise = 1'b1;
                  end
                  uartrm_pkg::OFF_IER: rd = ier_ff;
                  uartrm_pkg::OFF_IIR: begin
                     rd = {4'd0, pend_ff & uartrm_pkg::IIR_NOFIFO_MASK};
                     if ((pend_ff & uartrm_pkg::ID_THRE) != 4'd0) pend_in = uartrm_pkg::ID_NONE;
                  end
                  uartrm_pkg::OFF_LCR: rd = lcr_ff;
                  uartrm_pkg::OFF_LSR: rd = {2'b00, te_ff, 4'b0000, dr_ff};
                  default: rd = 8'd0;
               endcase
            end
         end
         default: begin
            // bus write
            if (off_full[15:3] != 13'd0) begin
               st = uartrm_pkg::ST_PORT;
            end else begin
               unique case (off)
                  uartrm_pkg::OFF_DATA: begin
                     if (dlab) begin
                        st = (req_payload.byte_count != 3'd1) ? uartrm_pkg::ST_SIZE
                                                              : uartrm_pkg::ST_OK;
                     end else if (!size_ok) begin
                        st = uartrm_pkg::ST_SIZE;
                     end else begin
                        is_tx = 1'b1;
                        te_in = 1'b1;
                        if ((pend_ff & uartrm_pkg::ID_THRE) != 4'd0) pend_in = uartrm_pkg::ID_NONE;
                        try_raise = 1'b1;
                     end
                  end
                  uartrm_pkg::OFF_IER: begin
                     if (req_payload.byte_count != 3'd1) begin
                        st = uartrm_pkg::ST_SIZE;
                     end else if (!dlab) begin
                        ier_in    = low;
                        try_raise = 1'b1;
                     end
                  end
                  uartrm_pkg::OFF_LCR: begin
                     if (req_payload.byte_count != 3'd1) st = uartrm_pkg::ST_SIZE;
                     else lcr_in = low;
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase

      // Interrupt raise on the updated state: receive first, then transmit-empty
      if (try_raise && pend_in == uartrm_pkg::ID_NONE) begin
         if (ier_in[uartrm_pkg::IER_RDA_BIT] && dr_in) raise_id = uartrm_pkg::ID_RDA;
         else if (ier_in[uartrm_pkg::IER_THRE_BIT] && te_in) raise_id = uartrm_pkg::ID_THRE;
         if (raise_id != uartrm_pkg::ID_NONE) begin
            if (req_payload.irq_route == uartrm_pkg::ROUTE_OK) begin
               pend_in = raise_id;
               raised  = 1'b1;
            end else if (req_payload.irq_route != uartrm_pkg::ROUTE_UNMAPPED) begin
               st = uartrm_pkg::ST_ROUTE;
            end
         end
      end
   end

   // Job for the back end
   always_comb begin
      push_job.read_data = rd;
      push_job.status    = st;
      push_job.irq_raise = raised;
      push_job.is_tx     = is_tx;
      push_job.count     = is_tx ? req_payload.byte_count : uartrm_pkg::COUNT_W'(1);
      push_job.data      = req_payload.write_data;
   end

   // Register state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= uartrm_pkg::BASE_PORT_RESET;
         rx_ff   <= 8'd0;
         dr_ff   <= 1'b0;
         te_ff   <= 1'b1;
         ier_ff  <= 8'd0;
         lcr_ff  <= 8'd0;
         pend_ff <= uartrm_pkg::ID_NONE;
      end else begin
         if (csr_we) base_ff <= csr_wdata;
         if (push) begin
            rx_ff   <= rx_in;
            dr_ff   <= dr_in;
            te_ff   <= te_in;
            ier_ff  <= ier_in;
            lcr_ff  <= lcr_in;
            pend_ff <= pend_in;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/uartrm_queue.sv -----
// Short job queue between the front end and the result sequencer.
`default_nettype none
module uartrm_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire uartrm_pkg::job_type push_job,
   output logic                 full,
   input  wire                  pop,
   output logic                 head_valid,
   output uartrm_pkg::job_type  head_job
);

   localparam int unsigned DEPTH = uartrm_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   uartrm_pkg::job_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/uartrm_back.sv -----
// Result sequencer: expands each job into one or more registered results.
`default_nettype none
module uartrm_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          head_valid,
   input  wire uartrm_pkg::job_type     head_job,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output uartrm_pkg::rsp_payload_type  rsp_payload
);

   logic [uartrm_pkg::COUNT_W-2:0] idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   uartrm_pkg::rsp_payload_type    rsp_ff, rsp_in;
   logic                           load;
   logic                           is_last;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign is_last = ({1'b0, idx_ff} + 1'b1) == head_job.count || !head_job.is_tx;
   assign pop     = load && head_valid && is_last;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next result from the head job
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_in.last = is_last;
            if (head_job.is_tx) begin
               rsp_in.read_data = 8'd0;
               rsp_in.status    = is_last ? head_job.status : uartrm_pkg::ST_OK;
               rsp_in.irq_raise = is_last && head_job.irq_raise;
               rsp_in.tx_valid  = 1'b1;
               rsp_in.tx_byte   = head_job.data[{idx_ff, 3'b000} +: 8];
            end else begin
               rsp_in.read_data = head_job.read_data;
               rsp_in.status    = head_job.status;
               rsp_in.irq_raise = head_job.irq_raise;
               rsp_in.tx_valid  = 1'b0;
               rsp_in.tx_byte   = 8'd0;
            end
            idx_in = is_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/uart_16550_register_model_core.sv -----
// UART register model: request decode, two-entry job queue, result output register.
// Flow: a request's job is written into the job queue when the request transfers; its first
// result is then loaded from the queue head into the output register once that register is free.
// Throughput: one result per cycle while rsp_ready allows; a transmitted data write of n bytes
// yields n results, one per byte, other requests one. Requests transfer every cycle while the job queue has room.
// Reset (synchronous, active high) restores base port 1016, transmit empty, no pending interrupt,
// and empties the queue and output register.
`default_nettype none
module uart_16550_register_model_core #(
   parameter int unsigned MAX_ACCESS_BYTES = uartrm_pkg::MAX_ACCESS_BYTES_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [15:0]                   csr_wdata,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire uartrm_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output uartrm_pkg::rsp_payload_type  rsp_payload
);

   logic                queue_full;
   logic                push;
   uartrm_pkg::job_type push_job;
   logic                pop;
   logic                head_valid;
   uartrm_pkg::job_type head_job;

   // Decode and register state
   uartrm_front #(
      .MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Job queue
   uartrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   // Result sequencing
   uartrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire

// ----- tb/uartrm_reg_checker.sv -----
// Checker for the UART register block: predicts responses from observed transfers and compares them.
`default_nettype none
module uartrm_reg_checker
   import uartrm_pkg::*;
#(
   parameter int unsigned MAX_BYTES = MAX_ACCESS_BYTES_DEFAULT
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             csr_we,
   input  wire [15:0]      csr_wdata,
   input  wire             req_valid,
   input  wire             req_ready,
   input  req_payload_type req_payload,
   input  wire             rsp_valid,
   input  wire             rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              due_count,
   output int              req_seen,
   output int              rsp_seen,
   output int              tx_seen,
   output int              irq_seen
);

   // Shadow copy of the register file
   logic [15:0] reg_base;
   logic [7:0]  rx_byte;
   logic        data_rdy;
   logic        thr_empty;
   logic [7:0]  ier;
   logic [7:0]  lcr;
   logic [3:0]  int_id;
   logic        irq_hit;

   // Responses still owed by the block, oldest first
   rsp_payload_type due_rsp_q[$];

   // Try to raise the next interrupt when none is pending
   function automatic logic [1:0] try_next_irq(input logic [1:0] route);
      logic [3:0] id;
      if (int_id != ID_NONE) return ST_OK;
      if (ier[IER_RDA_BIT] && data_rdy) id = ID_RDA;
      else if (ier[IER_THRE_BIT] && thr_empty) id = ID_THRE;
      else return ST_OK;
      if (route == ROUTE_UNMAPPED) return ST_OK;
      if (route != ROUTE_OK) return ST_ROUTE;
      int_id = id;
      irq_hit = 1'b1;
      return ST_OK;
   endfunction

   // Update the shadow state for one request and queue the responses it causes
   task automatic apply_request(input req_payload_type r);
      logic [15:0]     offs;
      logic [1:0]      st;
      logic [7:0]      rd;
      logic            dlab;
      int              n_tx;
      rsp_payload_type e;
      offs = r.port_address - reg_base;
      st = ST_OK;
      rd = '0;
      n_tx = 0;
      irq_hit = 1'b0;
      dlab = lcr[LCR_DLAB_BIT];
      if (req_kind_type'(r.req_type) == REQ_RX) begin
         rx_byte = r.write_data[7:0];
         data_rdy = 1'b1;
         st = try_next_irq(r.irq_route);
      end else if (req_kind_type'(r.req_type) == REQ_NONE) begin
         // meaningless request: all-zero response
      end else if (offs >= 16'd8) begin
         st = ST_PORT;
      end else if (req_kind_type'(r.req_type) == REQ_READ) begin
         case (reg_off_type'(offs[2:0]))
            OFF_DATA: begin
               rd = rx_byte;
               rx_byte = '0;
               data_rdy = 1'b0;
               if ((int_id & ID_RDA) != 0) int_id = ID_NONE;
               st = try_next_irq(r.irq_route);
            end
            OFF_IER: rd = ier;
            OFF_IIR: begin
               rd = {4'h0, int_id & IIR_NOFIFO_MASK};
               if ((int_id & ID_THRE) != 0) int_id = ID_NONE;
            end
            OFF_LCR: rd = lcr;
            OFF_LSR: rd = {2'b00, thr_empty, 4'b0000, data_rdy};
            default: rd = '0;
         endcase
      end else begin
         case (reg_off_type'(offs[2:0]))
            OFF_DATA: begin
               if (dlab) begin
                  st = (r.byte_count != 3'd1) ? ST_SIZE : ST_OK;
               end else if (r.byte_count < 1 || r.byte_count > MAX_BYTES) begin
                  st = ST_SIZE;
               end else begin
                  thr_empty = 1'b1;
                  if ((int_id & ID_THRE) != 0) int_id = ID_NONE;
                  st = try_next_irq(r.irq_route);
                  n_tx = int'(r.byte_count);
               end
            end
            OFF_IER: begin
               if (r.byte_count != 3'd1) begin
                  st = ST_SIZE;
               end else if (!dlab) begin
                  ier = r.write_data[7:0];
                  st = try_next_irq(r.irq_route);
               end
            end
            OFF_LCR: begin
               if (r.byte_count != 3'd1) st = ST_SIZE;
               else lcr = r.write_data[7:0];
            end
            default: ;
         endcase
      end

      // Transmit bytes go out lowest first; only the last one carries status
      if (n_tx > 0) begin
         for (int i = 0; i < n_tx; i++) begin
            e = '0;
            e.tx_valid = 1'b1;
            e.tx_byte = r.write_data[8*i +: 8];
            if (i == n_tx - 1) begin
               e.status = st;
               e.irq_raise = irq_hit;
               e.last = 1'b1;
            end
            due_rsp_q.push_back(e);
         end
      end else begin
         e = '0;
         e.read_data = rd;
         e.status = st;
         e.irq_raise = irq_hit;
         e.last = 1'b1;
         due_rsp_q.push_back(e);
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: response %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Compare one response transfer with the oldest expectation
   task automatic check_rsp(input rsp_payload_type got);
      rsp_payload_type want;
      if (due_rsp_q.size() == 0) begin
         $display("%0t: response with nothing due: expected none, actual %h", $time, got);
         fail_count++;
         return;
      end
      want = due_rsp_q.pop_front();
      check_field("read_data", want.read_data, got.read_data);
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("irq_raise", 8'(want.irq_raise), 8'(got.irq_raise));
      check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("last", 8'(want.last), 8'(got.last));
      if (got.tx_valid === 1'b1) tx_seen++;
      if (got.irq_raise === 1'b1) irq_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reg_base = BASE_PORT_RESET;
         rx_byte = '0;
         data_rdy = 1'b0;
         thr_empty = 1'b1;
         ier = '0;
         lcr = '0;
         int_id = ID_NONE;
         due_rsp_q.delete();
         fail_count = 0;
         req_seen = 0;
         rsp_seen = 0;
         tx_seen = 0;
         irq_seen = 0;
      end else begin
         // a response never belongs to a request transferred at the same edge
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            check_rsp(rsp_payload);
         end
         if (csr_we) reg_base = csr_wdata;
         if (req_valid && req_ready) begin
            req_seen++;
            apply_request(req_payload);
         end
      end
      due_count = due_rsp_q.size();
   end

endmodule
`default_nettype wire

// ----- tb/uart_16550_register_model_core_test.sv -----
// Top of the UART register block test: clock, reset, stimulus, flow control and verdict.
`default_nettype none
module uart_16550_register_model_core_test;
   import uartrm_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam logic [1:0] ROUTE_FAIL = 2'd0;
   localparam logic [1:0] ROUTE_BAD = 2'd3;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_we = 1'b0;
   logic [15:0]     csr_wdata = '0;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int fail_count;
   int due_count;
   int req_seen;
   int rsp_seen;
   int tx_seen;
   int irq_seen;

   logic [15:0] cur_base = BASE_PORT_RESET;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   uart_16550_register_model_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   uartrm_reg_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .due_count   (due_count),
      .req_seen    (req_seen),
      .rsp_seen    (rsp_seen),
      .tx_seen     (tx_seen),
      .irq_seen    (irq_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("uart_16550_register_model_core_test NOT OK");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one request, with random gaps, and wait for its transfer
   task automatic send_req(input req_payload_type p);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic reg_req(input req_kind_type kind, input int offs, input int size,
                          input logic [31:0] data, input logic [1:0] route);
      req_payload_type p;
      p.req_type = kind;
      p.port_address = cur_base + 16'(offs);
      p.byte_count = 3'(size);
      p.write_data = data;
      p.irq_route = route;
      send_req(p);
   endtask

   // Mostly decoded accesses; some stray ports and odd sizes
   function automatic req_payload_type random_request();
      req_payload_type r;
      int pick;
      int offs;
      pick = $urandom_range(99);
      r.write_data = $urandom;
      r.irq_route = ($urandom_range(3) != 0) ? ROUTE_OK : 2'($urandom_range(3));
      r.byte_count = ($urandom_range(4) != 0) ? 3'd1 : 3'($urandom_range(7));
      if (pick < 32) r.req_type = REQ_READ;
      else if (pick < 68) r.req_type = REQ_WRITE;
      else if (pick < 92) r.req_type = REQ_RX;
      else r.req_type = REQ_NONE;
      pick = $urandom_range(99);
      if (pick < 40) offs = OFF_DATA;
      else if (pick < 58) offs = OFF_IER;
      else if (pick < 72) offs = OFF_LCR;
      else offs = $urandom_range(7);
      if (r.req_type == REQ_WRITE && offs == OFF_DATA && $urandom_range(5) != 0)
         r.byte_count = 3'($urandom_range(MAX_ACCESS_BYTES_DEFAULT, 1));
      // keep the divisor latch set only part of the time
      if (r.req_type == REQ_WRITE && offs == OFF_LCR)
         r.write_data[7] = ($urandom_range(3) == 0);
      r.port_address = ($urandom_range(11) == 0) ? 16'($urandom) : cur_base + 16'(offs);
      return r;
   endfunction

   // Stop offering, wait until every response has come back, then let the pipeline drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_base(input logic [15:0] base);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= base;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_base = base;
   endtask

   task automatic random_burst();
      repeat (RANDOM_PER_PHASE) send_req(random_request());
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: every register read at reset
      for (int i = 0; i < 8; i++) reg_req(REQ_READ, i, 1, '0, ROUTE_OK);
      // interrupt raising, clearing and routing outcomes
      reg_req(REQ_WRITE, OFF_IER, 1, 32'h03, ROUTE_OK);
      reg_req(REQ_RX, 0, 1, 32'hA5, ROUTE_OK);
      reg_req(REQ_READ, OFF_IIR, 1, '0, ROUTE_OK);
      reg_req(REQ_READ, OFF_DATA, 1, '0, ROUTE_FAIL);
      reg_req(REQ_RX, 0, 1, 32'hFF, ROUTE_UNMAPPED);
      reg_req(REQ_RX, 0, 1, 32'h00, ROUTE_OK);
      reg_req(REQ_READ, OFF_DATA, 1, '0, ROUTE_BAD);
      // transmit sizes, good and bad
      reg_req(REQ_WRITE, OFF_DATA, 4, 32'hDEADBEEF, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_DATA, 0, 32'h12345678, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_DATA, 7, 32'hFFFFFFFF, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_IER, 2, 32'h01, ROUTE_OK);
      // divisor latch blocks data and enable writes
      reg_req(REQ_WRITE, OFF_LCR, 1, 32'h83, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_DATA, 1, 32'h41, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_DATA, 3, 32'h424344, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_IER, 1, 32'h00, ROUTE_OK);
      reg_req(REQ_READ, OFF_LCR, 1, '0, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_LCR, 4, 32'h00, ROUTE_OK);
      reg_req(REQ_WRITE, OFF_LCR, 1, 32'h00, ROUTE_OK);
      // ignored register, stray ports, meaningless request
      reg_req(REQ_WRITE, OFF_SCR, 7, 32'hFFFFFFFF, ROUTE_OK);
      reg_req(REQ_READ, 8, 1, '0, ROUTE_OK);
      reg_req(REQ_WRITE, 16'hFFFF, 1, 32'h55, ROUTE_OK);
      reg_req(REQ_NONE, OFF_DATA, 7, 32'hFFFFFFFF, ROUTE_BAD);

      // Random phases, each at its own base port and flow-control pattern
      random_burst();

      set_base(16'd0);
      send_gap_pct = 52;
      random_burst();

      set_base(16'd65528);
      send_gap_pct = 0;
      rsp_stall_pct = 52;
      hold_asked <= hold_asked + 1;
      random_burst();

      set_base(16'($urandom_range(65527, 1)));
      send_gap_pct = 25;
      rsp_stall_pct = 25;
      random_burst();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Run covered %0d requests and %0d responses (%0d transmit bytes, %0d interrupts).",
               req_seen, rsp_seen, tx_seen, irq_seen);
      $display("Four base ports incl. 0 and 65528, stalls on both sides, one long hold-off.");
      if (fail_count == 0 && due_count == 0) begin
         $display("uart_16550_register_model_core_test OK");
      end else begin
         $display("uart_16550_register_model_core_test NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
